// File: hw/rtl/md5_hash_engine_assert.svh
// Assertion macros for the MD5 hash engine.
// The macros sample on aclk and are disabled while aresetn is low.
`ifndef MD5_HASH_ENGINE_ASSERT_SVH
`define MD5_HASH_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

`define MD5_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

`define MD5_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define MD5_ASSERT_IMP(lbl, ante, cons)

`define MD5_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// File: hw/rtl/md5_pkg.sv
package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [6:0] LEN_START = 7'd56;
    localparam logic [6:0] BLK_BYTES = 7'd64;
    localparam logic [6:0] LAST_BYTE = 7'd63;

    typedef enum logic {
        OP_ABSORB = 1'b0,
        OP_FINISH = 1'b1
    } md5_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_DIGEST
    } md5_state_t;

    typedef enum logic [1:0] {
        BLK_DATA,
        BLK_SPILL,
        BLK_LAST
    } md5_blk_t;

    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5_s(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] md5_g(input logic [5:0] i);
        logic [3:0] g;
        case (i[5:4])
            2'd0: g = i[3:0];
            2'd1: g = (i[3:0] << 2) + i[3:0] + 4'd1;
            2'd2: g = (i[3:0] << 1) + i[3:0] + 4'd5;
            2'd3: g = (i[3:0] << 3) - i[3:0];
            default: g = 4'd0;
        endcase
        return g;
    endfunction

endpackage

// File: hw/rtl/md5_hash_engine.sv
// Channel | Direction | Fields (lowest bit first)
// s_      | input     | tuser: opcode; tdata: data_byte
// m_      | output    | tdata: digest_word_a, digest_word_b, digest_word_c, digest_word_d
//
// An absorb transfer writes one byte; the 64th byte of a block starts the rounds on the
// shared round unit, followed by the chaining update.
// A finish writes the pad marker, fills zeros and the bit length, compresses the block and
// then loads the digest; 56 or more buffered bytes add a zero-padded block before the last.
// Reset loads the initial chaining words and clears the bit counter; no clearing pass.
// A digest waits in the output register; a later finish stalls only if it is still held.
module md5_hash_engine
    import md5_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic [0:0]   s_tuser,   // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // digest_word_a, digest_word_b, digest_word_c, digest_word_d
);

    md5_state_t  state_reg, state_next;
    md5_blk_t    kind_reg, kind_next;
    logic [63:0] bit_len_reg, bit_len_next;
    logic [6:0]  ptr_reg, ptr_next;
    logic        spill_reg, spill_next;
    logic [5:0]  round_reg, round_next;
    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];
    logic [31:0] work_reg [4];
    logic [31:0] work_next [4];
    logic [31:0] buf_reg [16];
    logic        m_valid_reg, m_valid_next;
    logic [127:0] m_data_reg, m_data_next;

    logic        wr_en;
    logic [5:0]  wr_idx;
    logic [7:0]  wr_byte;

    logic        s_fire;
    logic [5:0]  fill_idx;
    logic        out_free;
    logic [31:0] f_val;
    logic [31:0] m_word;
    logic [31:0] round_sum;
    logic [63:0] rot_wide;
    logic [31:0] rot_val;
    logic [4:0]  rot_amt;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign fill_idx = bit_len_reg[8:3];
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        case (round_reg[5:4])
            2'd0: f_val = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
            2'd1: f_val = (work_reg[1] & work_reg[3]) | (work_reg[2] & ~work_reg[3]);
            2'd2: f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            2'd3: f_val = work_reg[2] ^ (work_reg[1] | ~work_reg[3]);
            default: f_val = '0;
        endcase
    end

    assign m_word    = buf_reg[md5_g(round_reg)];
    assign round_sum = work_reg[0] + f_val + md5_k(round_reg) + m_word;
    assign rot_amt   = md5_s(round_reg);
    assign rot_wide  = {round_sum, round_sum} << rot_amt;
    assign rot_val   = rot_wide[63:32];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_tuser[0] == OP_FINISH) begin
                        state_next = ST_PAD;
                    end else if (fill_idx == LAST_BYTE[5:0]) begin
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_PAD: begin
                if (ptr_reg == BLK_BYTES) begin
                    state_next = ST_ROUND;
                end else if (!(ptr_reg < LEN_START || spill_reg) && ptr_reg == LAST_BYTE) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (round_reg == LAST_BYTE[5:0]) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                case (kind_reg)
                    BLK_SPILL: state_next = ST_PAD;
                    BLK_LAST:  state_next = ST_DIGEST;
                    default:   state_next = ST_IDLE;
                endcase
            end
            ST_DIGEST: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        kind_next    = kind_reg;
        bit_len_next = bit_len_reg;
        ptr_next     = ptr_reg;
        spill_next   = spill_reg;
        round_next   = round_reg;
        chain_next   = chain_reg;
        work_next    = work_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;
        wr_en        = 1'b0;
        wr_idx       = ptr_reg[5:0];
        wr_byte      = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    wr_en  = 1'b1;
                    wr_idx = fill_idx;
                    if (s_tuser[0] == OP_FINISH) begin
                        wr_byte    = PAD_MARK;
                        ptr_next   = {1'b0, fill_idx} + 7'd1;
                        spill_next = ({1'b0, fill_idx} >= LEN_START);
                    end else begin
                        wr_byte      = s_tdata;
                        bit_len_next = bit_len_reg + 64'd8;
                        if (fill_idx == LAST_BYTE[5:0]) begin
                            kind_next = BLK_DATA;
                            work_next = chain_reg;
                        end
                    end
                end
            end
            ST_PAD: begin
                if (ptr_reg == BLK_BYTES) begin
                    kind_next  = BLK_SPILL;
                    work_next  = chain_reg;
                    ptr_next   = '0;
                    spill_next = 1'b0;
                end else if (ptr_reg < LEN_START || spill_reg) begin
                    wr_en    = 1'b1;
                    ptr_next = ptr_reg + 7'd1;
                end else begin
                    wr_en    = 1'b1;
                    wr_byte  = bit_len_reg[8 * ptr_reg[2:0] +: 8];
                    ptr_next = ptr_reg + 7'd1;
                    if (ptr_reg == LAST_BYTE) begin
                        kind_next = BLK_LAST;
                        work_next = chain_reg;
                    end
                end
            end
            ST_ROUND: begin
                work_next[0] = work_reg[3];
                work_next[1] = work_reg[1] + rot_val;
                work_next[2] = work_reg[1];
                work_next[3] = work_reg[2];
                round_next   = round_reg + 6'd1;
            end
            ST_ADD: begin
                for (int w = 0; w < 4; w++) begin
                    chain_next[w] = chain_reg[w] + work_reg[w];
                end
            end
            ST_DIGEST: begin
                if (out_free) begin
                    m_data_next  = {chain_reg[3], chain_reg[2], chain_reg[1], chain_reg[0]};
                    m_valid_next = 1'b1;
                    chain_next[0] = IV_A;
                    chain_next[1] = IV_B;
                    chain_next[2] = IV_C;
                    chain_next[3] = IV_D;
                    bit_len_next  = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            kind_reg     <= BLK_DATA;
            bit_len_reg  <= '0;
            ptr_reg      <= '0;
            spill_reg    <= 1'b0;
            round_reg    <= '0;
            m_valid_reg  <= 1'b0;
            chain_reg[0] <= IV_A;
            chain_reg[1] <= IV_B;
            chain_reg[2] <= IV_C;
            chain_reg[3] <= IV_D;
        end else begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            bit_len_reg <= bit_len_next;
            ptr_reg     <= ptr_next;
            spill_reg   <= spill_next;
            round_reg   <= round_next;
            m_valid_reg <= m_valid_next;
            chain_reg   <= chain_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg   <= work_next;
        m_data_reg <= m_data_next;
        if (wr_en) begin
            buf_reg[wr_idx[5:2]][8 * wr_idx[1:0] +: 8] <= wr_byte;
        end
    end

`include "md5_hash_engine_assert.svh"

    `MD5_ASSERT_IMP(a_round_idle_zero, state_reg != ST_ROUND, round_reg == '0)
    `MD5_ASSERT_IMP(a_pad_ptr_range, state_reg == ST_PAD, ptr_reg <= BLK_BYTES)
    `MD5_ASSERT_NXT(a_digest_restart, state_reg == ST_DIGEST && out_free, m_valid_reg && bit_len_reg == '0 && chain_reg[0] == IV_A)

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import md5_pkg::*;

    localparam int PHASE_ITEMS   = 290;
    localparam int MIN_DIGESTS   = 40;
    localparam int HOLD_CYCLES   = 1500;
    localparam int DRAIN_CYCLES  = 300;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int MAX_REPORTS   = 10;

    localparam logic [127:0] DIG_EMPTY = 128'h7e42f8ec_980980e9_04b2008f_d98c1dd4;
    localparam logic [127:0] DIG_A     = 128'h61267769_e299c331_a8b6f1c0_b975c10c;
    localparam logic [127:0] DIG_ABC   = 128'h727fe128_7d3f96d6_b04fd23c_98500190;

    typedef struct packed {
        md5_op_t      op;
        logic [7:0]   data;
        logic         known;
        logic [127:0] digest;
    } stim_row_t;

    localparam int N_ROWS = 13;

    stim_row_t dir_rows [N_ROWS] = '{
        '{OP_FINISH, 8'h00, 1'b1, DIG_EMPTY},
        '{OP_ABSORB, 8'h61, 1'b0, 128'h0},
        '{OP_FINISH, 8'h00, 1'b1, DIG_A},
        '{OP_ABSORB, 8'h61, 1'b0, 128'h0},
        '{OP_ABSORB, 8'h62, 1'b0, 128'h0},
        '{OP_ABSORB, 8'h63, 1'b0, 128'h0},
        '{OP_FINISH, 8'h00, 1'b1, DIG_ABC},
        '{OP_ABSORB, 8'h00, 1'b0, 128'h0},
        '{OP_ABSORB, 8'hff, 1'b0, 128'h0},
        '{OP_FINISH, 8'h00, 1'b0, 128'h0},
        '{OP_FINISH, 8'hff, 1'b1, DIG_EMPTY},
        '{OP_ABSORB, 8'hff, 1'b0, 128'h0},
        '{OP_FINISH, 8'hff, 1'b0, 128'h0}
    };

    logic [31:0] round_k [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    int rot_tab [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    int len_picks [12] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'h00;
    logic [0:0]   s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;

    logic [31:0]  hash_words [4];
    logic [63:0]  msg_bits;
    logic [7:0]   blk_bytes [64];
    logic [127:0] digest_q [$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    logic hold_tgl = 1'b0;
    logic hold_seen = 1'b0;
    int hold_left = 0;

    int err_cnt = 0;
    int cycle_cnt = 0;
    int n_items = 0;
    int n_msgs = 0;
    int n_spill = 0;
    int n_checked = 0;

    md5_hash_engine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic void restart_hash();
        hash_words[0] = IV_A;
        hash_words[1] = IV_B;
        hash_words[2] = IV_C;
        hash_words[3] = IV_D;
        msg_bits = 64'd0;
    endfunction

    function automatic void fold_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, f, t, sum;
        int g, sh;
        for (int i = 0; i < 16; i++) begin
            w[i] = {blk_bytes[4*i+3], blk_bytes[4*i+2], blk_bytes[4*i+1], blk_bytes[4*i]};
        end
        a = hash_words[0];
        b = hash_words[1];
        c = hash_words[2];
        d = hash_words[3];
        for (int i = 0; i < 64; i++) begin
            case (i / 16)
                0: begin
                    f = (b & c) | (~b & d);
                    g = i;
                end
                1: begin
                    f = (b & d) | (c & ~d);
                    g = (5 * i + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * i) % 16;
                end
            endcase
            sh = rot_tab[(i / 16) * 4 + i % 4];
            sum = a + f + round_k[i] + w[g];
            t = d;
            d = c;
            c = b;
            b = b + ((sum << sh) | (sum >> (32 - sh)));
            a = t;
        end
        hash_words[0] += a;
        hash_words[1] += b;
        hash_words[2] += c;
        hash_words[3] += d;
    endfunction

    function automatic void absorb_byte(input logic [7:0] data);
        int idx;
        idx = int'(msg_bits[8:3]);
        blk_bytes[idx] = data;
        msg_bits += 64'd8;
        if (idx == 63) begin
            fold_block();
        end
    endfunction

    function automatic logic [127:0] finish_digest();
        logic [63:0]  len;
        logic [127:0] dig;
        int idx;
        len = msg_bits;
        idx = int'(msg_bits[8:3]);
        if (idx >= 56) begin
            n_spill++;
        end
        blk_bytes[idx] = PAD_MARK;
        idx++;
        if (idx > 56) begin
            for (int k = idx; k < 64; k++) begin
                blk_bytes[k] = 8'h00;
            end
            fold_block();
            idx = 0;
        end
        for (int k = idx; k < 56; k++) begin
            blk_bytes[k] = 8'h00;
        end
        for (int k = 0; k < 8; k++) begin
            blk_bytes[56 + k] = len[8*k +: 8];
        end
        fold_block();
        dig = {hash_words[3], hash_words[2], hash_words[1], hash_words[0]};
        restart_hash();
        return dig;
    endfunction

    task automatic send_item(input md5_op_t op, input logic [7:0] data,
                             input logic known, input logic [127:0] known_dig);
        logic [127:0] dig;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        n_items++;
        if (op == OP_ABSORB) begin
            absorb_byte(data);
        end else begin
            dig = finish_digest();
            digest_q.push_back(known ? known_dig : dig);
            n_msgs++;
        end
    endtask

    task automatic wait_all_digests();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (digest_q.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (hold_tgl != hold_seen) begin
            hold_seen <= hold_tgl;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        logic [127:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (digest_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS) begin
                    $display("unexpected digest transfer: %h", m_tdata);
                end
            end else begin
                want = digest_q.pop_front();
                n_checked++;
                for (int w = 0; w < 4; w++) begin
                    if (m_tdata[32*w +: 32] !== want[32*w +: 32]) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS) begin
                            $display("digest %0d word %0d: expected %h, got %h",
                                     n_checked, w, want[32*w +: 32], m_tdata[32*w +: 32]);
                        end
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int msg_len;
        int r;
        int msgs_in_phase;
        restart_hash();
        for (int k = 0; k < 64; k++) begin
            blk_bytes[k] = 8'h00;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_ROWS; i++) begin
            send_item(dir_rows[i].op, dir_rows[i].data, dir_rows[i].known, dir_rows[i].digest);
        end

        for (int ph = 0; ph < 4; ph++) begin
            wait_all_digests();
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    stall_pct <= 0;
                end
                1: begin
                    send_idle_pct = 62;
                    stall_pct <= 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct <= 62;
                end
                default: begin
                    send_idle_pct = 20;
                    stall_pct <= 20;
                end
            endcase
            msgs_in_phase = 0;
            while (n_items < N_ROWS + (ph + 1) * PHASE_ITEMS
                   || (ph == 3 && n_msgs < MIN_DIGESTS)) begin
                if (ph == 0 && msgs_in_phase == 1) begin
                    hold_tgl <= ~hold_tgl;
                end
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    msg_len = len_picks[$urandom_range(0, 11)];
                end else if (r < 95) begin
                    msg_len = $urandom_range(0, 70);
                end else begin
                    msg_len = $urandom_range(100, 200);
                end
                for (int b = 0; b < msg_len; b++) begin
                    send_item(OP_ABSORB, 8'($urandom_range(0, 255)), 1'b0, 128'h0);
                end
                send_item(OP_FINISH, 8'($urandom_range(0, 255)), 1'b0, 128'h0);
                msgs_in_phase++;
            end
        end

        wait_all_digests();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (digest_q.size() != 0) begin
            err_cnt += digest_q.size();
        end
        $display("Sent %0d transfers forming %0d messages, %0d with a spilled padding block.",
                 n_items, n_msgs, n_spill);
        $display("Checked %0d digests under four idling phases and a long receiver hold-off.",
                 n_checked);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
